FILE: rtl/yaz0_pkg.sv
// Shared types and constants for the Yaz0 stream decompressor.
// No dependencies; used by the controller, the datapath and the top level.
package yaz0_pkg;

  // Input command codes.
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Status codes carried with every result beat.
  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_HDR_CUT   = 3'd3;
  localparam logic [2:0] ST_OVERRUN   = 3'd4;
  localparam logic [2:0] ST_TRAILING  = 3'd5;

  // History window and stream format constants.
  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned HIST_AW    = 12;
  localparam logic [4:0]  HEADER_LEN = 5'd16;
  localparam logic [5:0]  TRAIL_MAX  = 6'd63;
  localparam logic [5:0]  TRAIL_LIM  = 6'h20;
  localparam logic [8:0]  LONG_BIAS  = 9'h12;
  localparam logic [31:0] SIZE_SAT   = 32'h7FFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the input beat and decode it
    logic cp_rd;      // issue a history read for the next copied byte
    logic cp_wr;      // write the copied byte and pack it
    logic emit;       // move the pack register to the output register
    logic emit_last;  // the emitted beat closes the current item
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic will_copy;  // the offered input starts a back-reference copy
    logic pack_full;  // all output lanes hold bytes
    logic copy_last;  // the byte being written ends the copy
    logic out_free;   // the output register can take a beat
  } dp_stat_t;

  // Magic bytes "Yaz0", indexed from the first header byte.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h59;
      2'd1:    m = 8'h61;
      2'd2:    m = 8'h7A;
      default: m = 8'h30;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/yaz0_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module yaz0_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/yaz0_ctrl.sv
// Controller state machine for the Yaz0 decompressor.
// Depends on yaz0_pkg; drives the datapath command struct and the input stall.
module yaz0_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  yaz0_pkg::dp_stat_t stat,
  output yaz0_pkg::dp_cmd_t  cmd
);
  import yaz0_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RD    = 2'd1;
  localparam logic [1:0] S_WR    = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = stat.will_copy ? S_RD : S_FLUSH;
        end
      end
      S_RD: begin
        // A full pack goes out before the next byte is read.
        if (stat.pack_full) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
          end
        end else begin
          cmd.cp_rd  = 1'b1;
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.cp_wr  = 1'b1;
        state_next = stat.copy_last ? S_FLUSH : S_RD;
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/yaz0_dp.sv
// Datapath of the Yaz0 decompressor: header parse, flag decode, history copy,
// output packing and the result register. Depends on yaz0_pkg and yaz0_ram.
module yaz0_dp #(
  parameter int unsigned OUT_LANES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  yaz0_pkg::dp_cmd_t  cmd,
  output yaz0_pkg::dp_stat_t stat,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_data,
  input  logic               in_cmd,
  input  logic [7:0]         in_byte,
  input  logic               in_chunk_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_bytes,
  output logic [3:0]         out_count,
  output logic               out_last,
  output logic [2:0]         out_status,
  output logic [30:0]        out_remaining
);
  import yaz0_pkg::*;

  localparam int unsigned PW = OUT_LANES * 8;
  localparam int unsigned CW = $clog2(OUT_LANES + 1);

  // Decoder context.
  logic [30:0]        max_size;
  logic [4:0]         header_left,    header_left_next;
  logic [31:0]        bytes_left,     bytes_left_next;
  logic [7:0]         group_mask,     group_mask_next;
  logic [7:0]         group_flags,    group_flags_next;
  logic [7:0]         first_ref_byte, first_ref_byte_next;
  logic [1:0]         phase,          phase_next;
  logic [12:0]        copy_distance,  copy_distance_next;
  logic [HIST_AW-1:0] write_pos,      write_pos_next;
  logic [5:0]         trailing_count, trailing_count_next;
  logic [2:0]         error_code,     error_code_next;
  logic [8:0]         copy_cnt,       copy_cnt_next;
  logic [PW-1:0]      pack_data,      pack_data_next;
  logic [CW-1:0]      pack_cnt,       pack_cnt_next;

  logic               will_copy;
  logic [8:0]         copy_len;
  logic               lit_we;
  logic [4:0]         hl_n;
  logic [31:0]        bl_t;
  logic [15:0]        ref_word;
  logic               ram_we;
  logic [HIST_AW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [HIST_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;
  logic               pack_we;
  logic [7:0]         pack_byte;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;

  // Decode of one input beat; registers load only on an accept.
  always_comb begin
    header_left_next    = header_left;
    bytes_left_next     = bytes_left;
    group_mask_next     = group_mask;
    group_flags_next    = group_flags;
    first_ref_byte_next = first_ref_byte;
    phase_next          = phase;
    copy_distance_next  = copy_distance;
    trailing_count_next = trailing_count;
    error_code_next     = error_code;
    will_copy           = 1'b0;
    copy_len            = '0;
    lit_we              = 1'b0;
    hl_n                = header_left - 5'd1;
    bl_t                = bytes_left;
    ref_word            = {first_ref_byte, in_byte};

    if (in_cmd == CMD_RESTART) begin
      header_left_next    = HEADER_LEN;
      bytes_left_next     = '0;
      group_mask_next     = '0;
      group_flags_next    = '0;
      first_ref_byte_next = '0;
      phase_next          = '0;
      copy_distance_next  = '0;
      trailing_count_next = '0;
      error_code_next     = ST_RUNNING;
    end else if (error_code == ST_RUNNING) begin
      if (header_left != 5'd0) begin
        // Header: magic, big-endian size, then ignored bytes.
        header_left_next = hl_n;
        if (hl_n >= 5'd12) begin
          if (in_byte != magic_byte(~hl_n[1:0])) begin
            error_code_next = ST_BAD_MAGIC;
          end
        end else if (hl_n >= 5'd8) begin
          bl_t            = bytes_left | ({24'd0, in_byte} << {hl_n[1:0], 3'b000});
          bytes_left_next = bl_t;
        end
        if (hl_n == 5'd0) begin
          if (bl_t[31]) begin
            bl_t = SIZE_SAT;
          end
          if (max_size != 31'd0 && {1'b0, max_size} < bl_t) begin
            bl_t = {1'b0, max_size};
          end
          bytes_left_next = bl_t;
        end
      end else if (bytes_left != 32'd0) begin
        if (phase == 2'd2 || (phase == 2'd1 && ref_word[15:12] != 4'd0)) begin
          // Back-reference with its length complete.
          if (phase == 2'd2) begin
            copy_len = {1'b0, in_byte} + LONG_BIAS;
          end else begin
            copy_len           = {5'd0, ref_word[15:12]} + 9'd2;
            copy_distance_next = {1'b0, ref_word[11:0]} + 13'd1;
          end
          if ({23'd0, copy_len} > bytes_left) begin
            if (max_size == 31'd0) begin
              error_code_next = ST_OVERRUN;
            end else begin
              copy_len   = bytes_left[8:0];
              will_copy  = 1'b1;
              phase_next = 2'd0;
            end
          end else begin
            will_copy  = 1'b1;
            phase_next = 2'd0;
          end
        end else if (phase == 2'd1) begin
          // Long form: one more length byte follows.
          copy_distance_next = {1'b0, ref_word[11:0]} + 13'd1;
          phase_next         = 2'd2;
        end else if (group_mask == 8'd0) begin
          group_flags_next = in_byte;
          group_mask_next  = 8'h80;
        end else begin
          if ((group_flags & group_mask) != 8'd0) begin
            lit_we          = 1'b1;
            bytes_left_next = bytes_left - 32'd1;
          end else begin
            first_ref_byte_next = in_byte;
            phase_next          = 2'd1;
          end
          group_mask_next = group_mask >> 1;
        end
      end else if (trailing_count < TRAIL_MAX) begin
        trailing_count_next = trailing_count + 6'd1;
      end

      // Checks at the end of a chunk.
      if (in_chunk_end) begin
        if (error_code_next == ST_RUNNING) begin
          if (header_left_next != 5'd0) begin
            error_code_next = ST_HDR_CUT;
          end else if (bytes_left == 32'd0 && max_size == 31'd0 &&
                       trailing_count_next > TRAIL_LIM) begin
            error_code_next = ST_TRAILING;
          end
        end
        trailing_count_next = '0;
      end
    end
  end

  // History port, copy counter and packing.
  always_comb begin
    ram_raddr      = write_pos - copy_distance[HIST_AW-1:0];
    ram_we         = 1'b0;
    ram_waddr      = write_pos;
    ram_wdata      = in_byte;
    write_pos_next = write_pos;
    copy_cnt_next  = copy_cnt;
    pack_we        = 1'b0;
    pack_byte      = in_byte;
    if (cmd.accept) begin
      if (in_cmd == CMD_RESTART) begin
        write_pos_next = '0;
      end else if (lit_we) begin
        ram_we         = 1'b1;
        pack_we        = 1'b1;
        write_pos_next = write_pos + 1'b1;
      end
      if (will_copy) begin
        copy_cnt_next = copy_len;
      end
    end else if (cmd.cp_wr) begin
      ram_we         = 1'b1;
      ram_wdata      = ram_rdata;
      pack_we        = 1'b1;
      pack_byte      = ram_rdata;
      write_pos_next = write_pos + 1'b1;
      copy_cnt_next  = copy_cnt - 9'd1;
    end

    pack_data_next = pack_data;
    pack_cnt_next  = pack_cnt;
    if (cmd.emit) begin
      pack_data_next = '0;
      pack_cnt_next  = '0;
    end else if (pack_we) begin
      pack_data_next = pack_data | ({{(PW-8){1'b0}}, pack_byte} << {pack_cnt, 3'b000});
      pack_cnt_next  = pack_cnt + 1'b1;
    end
  end

  assign stat.will_copy = will_copy;
  assign stat.pack_full = (pack_cnt == CW'(OUT_LANES));
  assign stat.copy_last = (copy_cnt == 9'd1);
  assign stat.out_free  = out_free;

  yaz0_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Context registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_size       <= '0;
      header_left    <= HEADER_LEN;
      bytes_left     <= '0;
      group_mask     <= '0;
      group_flags    <= '0;
      first_ref_byte <= '0;
      phase          <= '0;
      copy_distance  <= '0;
      write_pos      <= '0;
      trailing_count <= '0;
      error_code     <= ST_RUNNING;
      copy_cnt       <= '0;
      pack_data      <= '0;
      pack_cnt       <= '0;
    end else begin
      if (cfg_we) begin
        max_size <= cfg_data;
      end
      if (cmd.accept) begin
        header_left    <= header_left_next;
        bytes_left     <= bytes_left_next;
        group_mask     <= group_mask_next;
        group_flags    <= group_flags_next;
        first_ref_byte <= first_ref_byte_next;
        phase          <= phase_next;
        copy_distance  <= copy_distance_next;
        trailing_count <= trailing_count_next;
        error_code     <= error_code_next;
      end else if (cmd.cp_wr) begin
        bytes_left <= bytes_left - 32'd1;
      end
      write_pos <= write_pos_next;
      copy_cnt  <= copy_cnt_next;
      pack_data <= pack_data_next;
      pack_cnt  <= pack_cnt_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bytes     <= 64'(pack_data);
      out_count     <= 4'(pack_cnt);
      out_last      <= cmd.emit_last;
      out_remaining <= (header_left != 5'd0) ? 31'd0 : bytes_left[30:0];
      if (error_code != ST_RUNNING) begin
        out_status <= error_code;
      end else if (header_left == 5'd0 && bytes_left == 32'd0) begin
        out_status <= ST_DONE;
      end else begin
        out_status <= ST_RUNNING;
      end
    end
  end

  // The pack never holds more bytes than there are lanes.
  a_pack_bound: assert property (@(posedge clk) disable iff (rst)
    pack_cnt <= CW'(OUT_LANES))
    else $error("pack count beyond lane count");

  // A beat is only emitted when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("emit into a stalled output register");

  // A copy write always has a byte left to copy.
  a_copy_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.cp_wr |-> copy_cnt != 9'd0)
    else $error("copy write with empty copy count");

  // Errors hold until a restart.
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_code != ST_RUNNING && !(cmd.accept && in_cmd == CMD_RESTART))
      |=> error_code == $past(error_code))
    else $error("error status changed without restart");

endmodule

FILE: rtl/yaz0_stream_decompressor_core.sv
// Top level of the Yaz0 stream decompressor.
// Depends on yaz0_pkg, yaz0_ctrl, yaz0_dp and yaz0_ram.
//
//  Channel  Handshake          Beat contents
//  in       in_valid/in_stall  cmd, in_byte, chunk_end
//  out      out_valid/out_stall out_bytes, out_count, last, status, remaining_size
//  cfg      cfg_valid/cfg_ready cfg_data (max_uncomp_size)
//
// A header, flag, literal or error beat is decoded, then its result beat goes out.
// A back-reference is decoded, then each byte takes a history read and then a write,
// set apart by the registered read of the history RAM; each full output word is emitted
// before the next byte is read.
// Reset is synchronous; the history RAM is not cleared and needs no sweep.
// An output stall holds the controller until the result register frees up.
module yaz0_stream_decompressor_core #(
  parameter int unsigned OUT_LANES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  in_byte,
  input  logic        chunk_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_count,
  output logic        last,
  output logic [2:0]  status,
  output logic [30:0] remaining_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data
);
  import yaz0_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // The register may be written at any time the block is idle.
  assign cfg_ready = 1'b1;

  yaz0_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  yaz0_dp #(
    .OUT_LANES (OUT_LANES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .in_cmd        (cmd),
    .in_byte       (in_byte),
    .in_chunk_end  (chunk_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bytes     (out_bytes),
    .out_count     (out_count),
    .out_last      (last),
    .out_status    (status),
    .out_remaining (remaining_size)
  );

endmodule

FILE: tb/yaz0_stream_decompressor_core_tb.sv
// Self-checking testbench for the Yaz0 stream decompressor core.
// Depends on yaz0_pkg and the RTL of yaz0_stream_decompressor_core.
// Streams are built from a built-in decoder model, so back-references stay in written history.
module yaz0_stream_decompressor_core_tb;
  import yaz0_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned RANDOM_ITEMS = 120;

  // One expected or observed output beat.
  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    logic [2:0]  status;
    logic [30:0] rem;
  } out_beat_t;

  // Decoder model plus the store of expected output beats.
  class yaz0_scoreboard;
    bit [30:0]   max_size;
    int unsigned header_left, bytes_left, group_mask, group_flags;
    int unsigned first_ref, phase, distance, write_pos, trail, err_code;
    int unsigned fill;
    bit [7:0]    hist [HIST_DEPTH];
    bit [7:0]    decoded [$];
    out_beat_t   pending_beats [$];
    int          errors;

    function void clear_context();
      header_left = HEADER_LEN;
      bytes_left = 0;
      group_mask = 0;
      group_flags = 0;
      first_ref = 0;
      phase = 0;
      distance = 0;
      write_pos = 0;
      trail = 0;
      err_code = ST_RUNNING;
      fill = 0;
    endfunction

    function void put_byte(bit [7:0] b);
      hist[write_pos] = b;
      write_pos = (write_pos + 1) % HIST_DEPTH;
      decoded.push_back(b);
      if (fill < HIST_DEPTH) fill++;
    endfunction

    function void copy_run(int unsigned len);
      int unsigned src;
      if (len > bytes_left) begin
        if (max_size == 0) begin
          err_code = ST_OVERRUN;
          return;
        end
        len = bytes_left;
      end
      bytes_left -= len;
      for (int unsigned i = 0; i < len; i++) begin
        src = (write_pos + HIST_DEPTH - distance) % HIST_DEPTH;
        put_byte(hist[src]);
      end
      phase = 0;
    endfunction

    function void header_step(bit [7:0] b);
      bit [7:0] magic [4];
      magic = '{8'h59, 8'h61, 8'h7A, 8'h30};
      header_left = (header_left - 1) & 31;
      if (header_left >= 12 && header_left <= 15) begin
        if (b != magic[15 - header_left]) begin
          err_code = ST_BAD_MAGIC;
          return;
        end
      end else if (header_left >= 8) begin
        bytes_left |= int'(b) << ((header_left - 8) * 8);
      end
      if (header_left == 0) begin
        if (bytes_left[31]) bytes_left = 32'h7FFF_FFFF;
        if (max_size > 0 && max_size < bytes_left) bytes_left = max_size;
      end
    endfunction

    function void data_step(bit [7:0] b);
      int unsigned word;
      if (phase == 2) begin
        copy_run(b + 18);
      end else if (phase == 1) begin
        word = (first_ref << 8) | b;
        distance = (word & 12'hFFF) + 1;
        if ((word >> 12) == 0) phase = 2;
        else copy_run((word >> 12) + 2);
      end else if (group_mask == 0) begin
        group_flags = b;
        group_mask = 8'h80;
      end else begin
        if ((group_flags & group_mask) != 0) begin
          put_byte(b);
          bytes_left--;
        end else begin
          first_ref = b;
          phase = 1;
        end
        group_mask >>= 1;
      end
    endfunction

    // Notes one accepted input beat and queues the beats it must cause.
    function void note_item(bit c, bit [7:0] b, bit ce);
      int unsigned prior_left, off, cnt;
      out_beat_t beat;
      decoded = {};
      if (c == CMD_RESTART) begin
        clear_context();
        beat = '{64'd0, 4'd0, 1'b1, ST_RUNNING, 31'd0};
        pending_beats.push_back(beat);
        return;
      end
      if (err_code == 0) begin
        if (header_left != 0) header_step(b);
        else if (bytes_left > 0) data_step(b);
        else if (trail < TRAIL_MAX) trail++;
        if (ce && err_code == 0) begin
          if (header_left != 0) err_code = ST_HDR_CUT;
          else if (bytes_left == 0 && max_size == 0 && trail > TRAIL_LIM)
            err_code = ST_TRAILING;
        end
        if (ce) trail = 0;
      end
      prior_left = bytes_left + decoded.size();
      off = 0;
      do begin
        cnt = decoded.size() - off;
        if (cnt > 8) cnt = 8;
        beat.bytes = '0;
        for (int unsigned k = 0; k < cnt; k++) beat.bytes[8*k +: 8] = decoded[off + k];
        off += cnt;
        beat.count = 4'(cnt);
        beat.last = (off >= decoded.size());
        beat.rem = (header_left != 0) ? 31'd0 : 31'(prior_left - off);
        if (err_code != 0) beat.status = 3'(err_code);
        else beat.status = (header_left == 0 && beat.rem == 0) ? ST_DONE : ST_RUNNING;
        pending_beats.push_back(beat);
      end while (off < decoded.size());
    endfunction

    // Compares one accepted output beat with the oldest expectation.
    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (pending_beats.size() == 0) begin
        $error("output beat with nothing expected");
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      if (got.bytes !== want.bytes) begin
        $error("out_bytes expected %h actual %h", want.bytes, got.bytes);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("out_count expected %0d actual %0d", want.count, got.count);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.rem !== want.rem) begin
        $error("remaining_size expected %0d actual %0d", want.rem, got.rem);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CMD_DATA;
  logic [7:0]  in_byte = 8'd0;
  logic        chunk_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_bytes;
  logic [3:0]  out_count;
  logic        last;
  logic [2:0]  status;
  logic [30:0] remaining_size;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = 31'd0;

  yaz0_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    items_sent = 0;
  bit             send_gaps = 1'b1;
  bit             recv_gaps = 1'b1;
  int unsigned    stall_left = 0;
  bit [7:0]       pending_low = 8'd0;
  bit             out_take = 1'b0;
  out_beat_t      out_seen;

  yaz0_stream_decompressor_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .in_byte(in_byte), .chunk_end(chunk_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bytes(out_bytes), .out_count(out_count), .last(last),
    .status(status), .remaining_size(remaining_size),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample the result channel mid-cycle, away from the driving edge.
  always @(negedge clk) begin
    out_take = out_valid && !out_stall && !rst;
    out_seen = '{out_bytes, out_count, last, status, remaining_size};
  end

  // Check accepted result beats and draw the receiver's stall for the next one.
  always @(posedge clk) begin
    int unsigned next_left;
    next_left = stall_left;
    if (out_take) begin
      sb.check_beat(out_seen);
      next_left = recv_gaps ? $urandom_range(0, 10) : 0;
    end else if (next_left > 0) begin
      next_left--;
    end
    stall_left = next_left;
    out_stall <= (next_left > 0);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sends one input beat after a random gap and waits until it is taken.
  // The valid drop of the previous beat always lands on an earlier edge.
  task automatic send_item(bit c, bit [7:0] b, bit ce);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 10) : 0;
    repeat (gap + 1) @(posedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    in_byte <= b;
    chunk_end <= ce;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sb.note_item(c, b, ce);
    items_sent++;
    in_valid <= 1'b0;
  endtask

  // Waits until every expected result has arrived.
  task automatic wait_drain();
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(bit [30:0] value);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    sb.max_size = value;
  endtask

  // Picks the next compressed byte so that copies only reach written history.
  function automatic bit [7:0] next_data_byte();
    bit [7:0] b;
    int unsigned ref_dist;
    b = 8'($urandom_range(0, 255));
    if (sb.header_left != 0 || sb.err_code != 0 || sb.bytes_left == 0) return b;
    if (sb.phase == 2) return ($urandom_range(0, 7) == 0) ? b : 8'($urandom_range(0, 20));
    if (sb.phase == 1) return pending_low;
    if (sb.group_mask == 0) begin
      if (sb.fill == 0) b[7] = 1'b1;
      return b;
    end
    if ((sb.group_flags & sb.group_mask) != 0) return b;
    ref_dist = $urandom_range(1, sb.fill);
    pending_low = 8'(ref_dist - 1);
    return {4'($urandom_range(0, 15)), 4'((ref_dist - 1) >> 8)};
  endfunction

  // One stream: restart, header (possibly broken), data, then trailing bytes.
  task automatic send_stream(bit [31:0] size, int bad_at, int cut_at,
                             int unsigned n_data, int unsigned n_trail, bit trail_ce);
    bit [7:0] magic [4];
    bit [7:0] b;
    magic = '{8'h59, 8'h61, 8'h7A, 8'h30};
    send_item(CMD_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < 16; i++) begin
      if (i < 4) b = magic[i];
      else if (i < 8) b = size[8*(7 - i) +: 8];
      else b = 8'($urandom_range(0, 255));
      if (i == bad_at) b ^= 8'($urandom_range(1, 255));
      send_item(CMD_DATA, b, i == cut_at);
    end
    for (int unsigned i = 0; i < n_data; i++) begin
      if (sb.err_code != 0 || sb.bytes_left == 0) break;
      send_item(CMD_DATA, next_data_byte(), $urandom_range(0, 15) == 0);
    end
    for (int unsigned i = 0; i < n_trail; i++)
      send_item(CMD_DATA, 8'($urandom_range(0, 255)),
                (i == n_trail - 1) ? trail_ce : 1'b0);
  endtask

  task automatic random_phase(bit [30:0] limit, int unsigned quota);
    bit [31:0]   size;
    int unsigned start, pick;
    bit          trail_long;
    write_limit(limit);
    start = items_sent;
    while (items_sent - start < quota) begin
      send_gaps = $urandom_range(0, 3) != 0;
      recv_gaps = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 9);
      if (pick == 0) size = {1'b1, 31'($urandom)};
      else if (pick == 1) size = $urandom_range(100, 600);
      else size = $urandom_range(0, 60);
      trail_long = $urandom_range(0, 3) == 0;
      send_stream(size,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 14) : -1,
                  $urandom_range(10, 60),
                  trail_long ? $urandom_range(30, 40) : $urandom_range(0, 3),
                  trail_long ? 1'b1 : 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    bit [7:0] directed [$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed stream in strict mode: literal extremes, a short copy with
    // overlap, then a long copy that overruns the declared size.
    write_limit(31'd0);
    directed = {8'h59, 8'h61, 8'h7A, 8'h30, 8'h00, 8'h00, 8'h00, 8'd21,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'hC0, 8'h00, 8'hFF, 8'hF0, 8'h01, 8'h00, 8'h00, 8'h00};
    send_item(CMD_RESTART, 8'h00, 1'b0);
    foreach (directed[i]) send_item(CMD_DATA, directed[i], 1'b0);

    // Hold the sender until everything has drained, then continue.
    wait_drain();

    random_phase(31'd0, RANDOM_ITEMS / 4);
    random_phase(31'd1, RANDOM_ITEMS / 8);
    random_phase(31'h7FFF_FFFF, RANDOM_ITEMS / 4);
    random_phase(31'($urandom_range(2, 40)), RANDOM_ITEMS / 4);
    random_phase(31'd0, RANDOM_ITEMS / 8);

    wait_drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (sb.pending_beats.size() != 0)
        $error("%0d expected beats never arrived", sb.pending_beats.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
